>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the modular exponentiation core.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> src/mexp_pkg.sv
// Package for the modular exponentiation core: field widths, reset value and
// sequencer state codes. No dependencies.
package mexp_pkg;

    // Field widths.
    localparam int MOD_W  = 31;
    localparam int BASE_W = 63;
    localparam int EXP_W  = 63;
    localparam int CNT_W  = 6;

    // Modulus after reset.
    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_SQR    = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    typedef logic [MOD_W-1:0] t_residue;

endpackage

>>> src/modular_exponentiation_core.sv
// Modular exponentiation core: base ** exponent mod modulus, right to left.
// Uses mexp_pkg and assert_macros.svh.
//
// Usage:
//   Input stream (s_axis_*): one beat carries a base and an exponent. It is
//   accepted when s_axis_tvalid and s_axis_tready are both high.
//   Output stream (m_axis_*): one beat per input beat with the power result.
//   Configuration: i_cfg_wr_en writes i_cfg_wr_data into the modulus register;
//   write it only while no item is in flight.
// Datapath: one shared shift-add-reduce unit does all the arithmetic, one
//   multiplier bit per cycle. The base is first reduced, then each scanned
//   exponent bit costs a squaring plus a multiply when the bit is set; the
//   highest set bit needs no squaring.
// Flow: one item at a time; s_axis_tready is high only while the sequencer
//   is idle, and the next beat can be taken in the cycle after the load.
//   A finished result sits in the output register, so a new item is taken
//   while the receiver still holds off. Reset: synchronous, active low; the
//   modulus returns to 1000000007, the output register empties, and a second
//   finished result waits in the sequencer until the register frees.
`include "assert_macros.svh"

module modular_exponentiation_core #(
    parameter int EXP_BITS = 63
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port.
    input  logic         i_cfg_wr_en,
    input  logic [30:0]  i_cfg_wr_data,   // modulus
    // Input stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,    // [62:0] base_value, [125:63] exponent, zero pad
    // Output stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata     // [30:0] power_result, zero pad
);

    localparam int MW = mexp_pkg::MOD_W;
    localparam int BW = mexp_pkg::BASE_W;
    localparam int CW = mexp_pkg::CNT_W;

    logic [2:0]             r_state;
    logic [MW-1:0]          r_modulus;
    logic [BW-1:0]          r_src;
    logic [EXP_BITS-1:0]    r_exp;
    mexp_pkg::t_residue     r_acc;
    mexp_pkg::t_residue     r_base;
    mexp_pkg::t_residue     r_mop;
    mexp_pkg::t_residue     r_part;
    logic [CW-1:0]          r_cnt;
    logic                   r_out_valid;
    mexp_pkg::t_residue     r_out_data;

    logic                   in_beat;
    logic                   out_free;
    logic                   exp_rest_zero;
    mexp_pkg::t_residue     addend;
    logic [MW+1:0]          mod_ext;
    logic [MW+1:0]          sum0;
    logic [MW+1:0]          sum1;
    logic [MW+1:0]          sum2;
    mexp_pkg::t_residue     n_part;

    assign s_axis_tready = (r_state == mexp_pkg::ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign exp_rest_zero = ((r_exp >> 1) == '0);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_data};

    // Shared unit: part = 2*part + addend, then up to two subtractions of the modulus.
    always_comb begin
        if (r_state == mexp_pkg::ST_REDUCE) begin
            addend = {{(MW-1){1'b0}}, r_src[BW-1]};
        end else begin
            addend = r_mop[MW-1] ? r_base : '0;
        end
        mod_ext = {2'b00, r_modulus};
        sum0    = {1'b0, r_part, 1'b0} + {2'b00, addend};
        sum1    = (sum0 >= mod_ext) ? (sum0 - mod_ext) : sum0;
        sum2    = (sum1 >= mod_ext) ? (sum1 - mod_ext) : sum1;
        n_part  = sum2[MW-1:0];
    end

    // Modulus register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= mexp_pkg::MODULUS_RESET;
        end else if (i_cfg_wr_en) begin
            r_modulus <= i_cfg_wr_data;
        end
    end

    // Sequencer: base reduction, then squares, with a multiply per set exponent bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mexp_pkg::ST_IDLE;
        end else begin
            unique case (r_state)
                mexp_pkg::ST_IDLE: begin
                    if (in_beat) begin
                        r_state <= mexp_pkg::ST_REDUCE;
                    end
                end
                mexp_pkg::ST_REDUCE: begin
                    if (r_cnt == '0) begin
                        if (r_exp == '0) begin
                            r_state <= mexp_pkg::ST_DONE;
                        end else if (r_exp[0]) begin
                            r_state <= mexp_pkg::ST_MUL;
                        end else begin
                            r_state <= mexp_pkg::ST_SQR;
                        end
                    end
                end
                mexp_pkg::ST_MUL: begin
                    if (r_cnt == '0) begin
                        r_state <= exp_rest_zero ? mexp_pkg::ST_DONE : mexp_pkg::ST_SQR;
                    end
                end
                mexp_pkg::ST_SQR: begin
                    if (r_cnt == '0) begin
                        if (exp_rest_zero) begin
                            r_state <= mexp_pkg::ST_DONE;
                        end else if (r_exp[1 % EXP_BITS] && EXP_BITS > 1) begin
                            r_state <= mexp_pkg::ST_MUL;
                        end else begin
                            r_state <= mexp_pkg::ST_SQR;
                        end
                    end
                end
                mexp_pkg::ST_DONE: begin
                    if (out_free) begin
                        r_state <= mexp_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= mexp_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            mexp_pkg::ST_IDLE: begin
                if (in_beat) begin
                    r_src  <= s_axis_tdata[BW-1:0];
                    r_exp  <= s_axis_tdata[BW +: EXP_BITS];
                    r_part <= '0;
                    r_cnt  <= CW'(BW - 1);
                    r_acc  <= (r_modulus <= MW'(1)) ? '0 : MW'(1);
                end
            end
            mexp_pkg::ST_REDUCE: begin
                r_src <= r_src << 1;
                if (r_cnt == '0) begin
                    r_base <= n_part;
                    r_part <= '0;
                    r_cnt  <= CW'(MW - 1);
                    r_mop  <= r_exp[0] ? r_acc : n_part;
                end else begin
                    r_part <= n_part;
                    r_cnt  <= r_cnt - 1'b1;
                end
            end
            mexp_pkg::ST_MUL: begin
                if (r_cnt == '0) begin
                    r_acc  <= n_part;
                    r_part <= '0;
                    r_cnt  <= CW'(MW - 1);
                    r_mop  <= r_base;
                end else begin
                    r_mop  <= r_mop << 1;
                    r_part <= n_part;
                    r_cnt  <= r_cnt - 1'b1;
                end
            end
            mexp_pkg::ST_SQR: begin
                if (r_cnt == '0) begin
                    r_base <= n_part;
                    r_exp  <= r_exp >> 1;
                    r_part <= '0;
                    r_cnt  <= CW'(MW - 1);
                    r_mop  <= (r_exp[1 % EXP_BITS] && EXP_BITS > 1) ? r_acc : n_part;
                end else begin
                    r_mop  <= r_mop << 1;
                    r_part <= n_part;
                    r_cnt  <= r_cnt - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: loaded from the sequencer, emptied by the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == mexp_pkg::ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mexp_pkg::ST_DONE && out_free) begin
            r_out_data <= (r_modulus == '0) ? '0 : r_acc;
        end
    end

    // A beat accepted starts the base reduction and closes the input.
    `ASSERT_CLK(a_start_reduce, i_clk, i_rst_n,
        in_beat |=> (r_state == mexp_pkg::ST_REDUCE) && !s_axis_tready)
    // The partial remainder stays below a nonzero modulus during multiply and square passes.
    `ASSERT_NEVER(a_part_range, i_clk, i_rst_n,
        (r_state == mexp_pkg::ST_MUL || r_state == mexp_pkg::ST_SQR)
        && r_modulus != '0 && r_part >= r_modulus)
    // Multiply and square passes count at most one step per modulus bit.
    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n,
        (r_state == mexp_pkg::ST_MUL || r_state == mexp_pkg::ST_SQR) && r_cnt > CW'(MW - 1))
    // A result offered downstream is a residue of the nonzero modulus.
    `ASSERT_NEVER(a_result_range, i_clk, i_rst_n,
        r_out_valid && r_modulus != '0 && r_out_data >= r_modulus)

endmodule
